/* rtl/rpd_pkg.sv */
package rpd_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int RUN_MAX    = MAX_WIDTH * MAX_HEIGHT;

    localparam int COL_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
    localparam int CNT_W = $clog2(RUN_MAX + 1);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        KIND_RUN   = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_RUN_BIG      = 3'd0,
        ERR_TOO_TALL     = 3'd1,
        ERR_P_INCOMPLETE = 3'd2,
        ERR_UNKNOWN      = 3'd3,
        ERR_TOO_WIDE     = 3'd4
    } err_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] col_start;
        logic [7:0] row_index;
        logic [8:0] run_length;
        logic [4:0] cell_state;
        logic [8:0] extent_width;
        logic [8:0] extent_height;
        err_t       error_code;
        logic       last;
    } result_t;

    typedef struct packed {
        result_t first;
        logic    then_done;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

/* rtl/rle_pattern_decoder.sv */
// channel   dir  beat contents
// --------  ---  ---------------------------------------------------------
// s_axis    in   tdata text_byte[7:0]; tlast end_of_text
// m_axis    out  tdata col/row/length/state/extents/error; tuser kind;
//                tlast last
//
// one text byte taken per cycle while the result queue has room
// each result is one output beat; a byte giving a run record and a done
// result gives two beats, a byte with no result gives none
// four queue entries sit between the parser and the output register
// rst_n is asynchronous; no clearing pass, s_tready high straight out of reset
// a stalled output fills the queue, then s_tready drops
module rle_pattern_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // col_start, row_index, run_length, cell_state,
                                   // extent_width, extent_height, error_code
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast
);

    logic             accept;
    logic             push;
    logic             pop;
    rpd_pkg::entry_t  front_entry;
    rpd_pkg::entry_t  queue_entry;
    rpd_pkg::qstat_t  qstat;
    rpd_pkg::result_t out_res;

    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;

    rpd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_byte   (s_tdata),
        .end_of_text (s_tlast),
        .accept      (accept),
        .push        (push),
        .entry       (front_entry)
    );

    rpd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .entry_in  (front_entry),
        .pop       (pop),
        .entry_out (queue_entry),
        .stat      (qstat)
    );

    rpd_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (qstat),
        .entry     (queue_entry),
        .pop       (pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_res   (out_res)
    );

    assign m_tdata = {5'b00000, out_res.error_code, out_res.extent_height,
                      out_res.extent_width, out_res.cell_state, out_res.run_length,
                      out_res.row_index, out_res.col_start};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

/* rtl/rpd_front.sv */
module rpd_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       text_byte,
    input  logic             end_of_text,
    input  logic             accept,
    output logic             push,
    output rpd_pkg::entry_t  entry
);

    localparam int CNT_W = rpd_pkg::CNT_W;
    localparam int COL_W = rpd_pkg::COL_W;
    localparam int ROW_W = rpd_pkg::ROW_W;
    localparam int SUM_W = CNT_W + 1;
    localparam int MUL_W = CNT_W + 4;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_P      = 8'h70;
    localparam logic [7:0] CH_PU     = 8'h50;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_Z      = 8'h5A;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_BU     = 8'h42;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_O      = 8'h6F;
    localparam logic [7:0] CH_OU     = 8'h4F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;

    logic             header_reg, header_next;
    logic             comment_reg, comment_next;
    logic             await_reg, await_next;
    logic             finished_reg, finished_next;
    logic [COL_W-1:0] column_reg, column_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [COL_W-1:0] width_reg, width_next;
    logic [ROW_W-1:0] height_reg, height_next;

    logic             is_digit;
    logic             is_space;
    logic [MUL_W-1:0] count_x10;
    logic [CNT_W-1:0] n_eff;
    logic [SUM_W-1:0] col_sum;
    logic [SUM_W-1:0] row_sum;
    logic [ROW_W:0]   row_plus1;
    logic [7:0]       letter_off;

    logic             place_req;
    logic [4:0]       place_st;
    logic             place_ok;
    logic             fail_req;
    rpd_pkg::err_t    fail_code;
    logic             bang;
    logic             emit;
    logic             done_follow;
    logic [COL_W-1:0] width_upd;
    logic [ROW_W-1:0] height_upd;
    logic [COL_W-1:0] column_upd;
    logic [ROW_W-1:0] row_upd;
    logic [CNT_W-1:0] count_upd;
    logic             header_upd;
    logic             comment_upd;
    rpd_pkg::result_t res;
    rpd_pkg::result_t done_res;

    assign is_digit   = (text_byte >= CH_0) && (text_byte <= CH_9);
    assign is_space   = (text_byte == CH_SP) || ((text_byte >= CH_TAB) && (text_byte <= CH_CR));
    assign count_x10  = {1'b0, count_reg, 3'b000} + {3'b000, count_reg, 1'b0}
                        + {{(MUL_W-4){1'b0}}, text_byte[3:0]};
    assign n_eff      = (count_reg == '0) ? CNT_W'(1) : count_reg;
    assign col_sum    = SUM_W'(column_reg) + SUM_W'(n_eff);
    assign row_sum    = SUM_W'(row_reg) + SUM_W'(n_eff);
    assign row_plus1  = {1'b0, row_reg} + (ROW_W+1)'(1);
    assign letter_off = text_byte - CH_A;

    always_comb
    begin
        header_upd  = header_reg;
        comment_upd = comment_reg;
        await_next  = await_reg;
        column_upd  = column_reg;
        row_upd     = row_reg;
        count_upd   = count_reg;
        width_upd   = width_reg;
        height_upd  = height_reg;
        place_req   = 1'b0;
        place_st    = '0;
        place_ok    = 1'b0;
        fail_req    = 1'b0;
        fail_code   = rpd_pkg::ERR_UNKNOWN;
        bang        = 1'b0;

        if (!finished_reg)
        begin
            if (await_reg)
            begin
                await_next = 1'b0;
                if (is_digit)
                begin
                    place_req = 1'b1;
                    place_st  = {1'b0, text_byte[3:0]};
                end
                else
                begin
                    fail_req  = 1'b1;
                    fail_code = rpd_pkg::ERR_P_INCOMPLETE;
                end
            end
            else if (comment_reg)
            begin
                if (text_byte == CH_NL)
                    comment_upd = 1'b0;
            end
            else if (text_byte == CH_HASH)
            begin
                comment_upd = 1'b1;
            end
            else if (header_reg || (text_byte == CH_X))
            begin
                header_upd = (text_byte != CH_NL);
            end
            else if (is_space)
            begin
                header_upd = header_reg;
            end
            else if (is_digit)
            begin
                if (count_x10 > MUL_W'(rpd_pkg::RUN_MAX))
                begin
                    fail_req  = 1'b1;
                    fail_code = rpd_pkg::ERR_RUN_BIG;
                end
                else
                begin
                    count_upd = count_x10[CNT_W-1:0];
                end
            end
            else
            begin
                count_upd = n_eff;
                priority if (text_byte == CH_BANG)
                begin
                    bang = 1'b1;
                end
                else if (text_byte == CH_DOLLAR)
                begin
                    column_upd = '0;
                    count_upd  = '0;
                    if (row_sum > SUM_W'(rpd_pkg::MAX_HEIGHT))
                    begin
                        fail_req  = 1'b1;
                        fail_code = rpd_pkg::ERR_TOO_TALL;
                    end
                    else
                    begin
                        row_upd = row_sum[ROW_W-1:0];
                    end
                end
                else if ((text_byte == CH_P) || (text_byte == CH_PU))
                begin
                    if (end_of_text)
                    begin
                        fail_req  = 1'b1;
                        fail_code = rpd_pkg::ERR_P_INCOMPLETE;
                    end
                    else
                    begin
                        await_next = 1'b1;
                    end
                end
                else if ((text_byte == CH_B) || (text_byte == CH_BU) || (text_byte == CH_DOT))
                begin
                    place_req = 1'b1;
                    place_st  = 5'd1;
                end
                else if ((text_byte == CH_O) || (text_byte == CH_OU) ||
                         (text_byte == CH_STAR) || (text_byte == CH_A))
                begin
                    place_req = 1'b1;
                    place_st  = 5'd0;
                end
                else if ((text_byte >= CH_C) && (text_byte <= CH_Z))
                begin
                    place_req = 1'b1;
                    place_st  = letter_off[4:0];
                end
                else
                begin
                    fail_req  = 1'b1;
                    fail_code = rpd_pkg::ERR_UNKNOWN;
                end
            end

            if (place_req)
            begin
                if (row_reg >= ROW_W'(rpd_pkg::MAX_HEIGHT))
                begin
                    fail_req  = 1'b1;
                    fail_code = rpd_pkg::ERR_TOO_TALL;
                end
                else if (col_sum > SUM_W'(rpd_pkg::MAX_WIDTH))
                begin
                    fail_req  = 1'b1;
                    fail_code = rpd_pkg::ERR_TOO_WIDE;
                end
                else
                begin
                    place_ok = 1'b1;
                    if (col_sum > SUM_W'(width_reg))
                        width_upd = col_sum[COL_W-1:0];
                    if (row_plus1 > (ROW_W+1)'(height_reg))
                        height_upd = row_plus1[ROW_W-1:0];
                    column_upd = col_sum[COL_W-1:0];
                    count_upd  = '0;
                end
            end
        end
    end

    always_comb
    begin
        emit          = place_ok || fail_req || bang;
        finished_next = finished_reg || fail_req || bang;
        done_follow   = end_of_text && !finished_next;

        res               = '0;
        res.extent_width  = 9'(width_upd);
        res.extent_height = 9'(height_upd);
        priority if (place_ok)
        begin
            res.kind       = rpd_pkg::KIND_RUN;
            res.col_start  = column_reg[7:0];
            res.row_index  = row_reg[7:0];
            res.run_length = n_eff[8:0];
            res.cell_state = place_st;
            res.error_code = rpd_pkg::ERR_RUN_BIG;
            res.last       = 1'b0;
        end
        else if (fail_req)
        begin
            res.kind       = rpd_pkg::KIND_ERROR;
            res.error_code = fail_code;
            res.last       = 1'b1;
        end
        else
        begin
            res.kind       = rpd_pkg::KIND_DONE;
            res.error_code = rpd_pkg::ERR_RUN_BIG;
            res.last       = 1'b1;
        end

        done_res            = '0;
        done_res.kind       = rpd_pkg::KIND_DONE;
        done_res.extent_width  = 9'(width_upd);
        done_res.extent_height = 9'(height_upd);
        done_res.error_code = rpd_pkg::ERR_RUN_BIG;
        done_res.last       = 1'b1;

        entry.first     = emit ? res : done_res;
        entry.then_done = emit && done_follow;
        push            = accept && (emit || done_follow);

        header_next  = header_upd;
        comment_next = comment_upd;
        column_next  = column_upd;
        row_next     = row_upd;
        count_next   = count_upd;
        width_next   = width_upd;
        height_next  = height_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg   <= 1'b0;
            comment_reg  <= 1'b0;
            await_reg    <= 1'b0;
            finished_reg <= 1'b0;
            column_reg   <= '0;
            row_reg      <= '0;
            count_reg    <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
        end
        else if (accept)
        begin
            if (end_of_text)
            begin
                header_reg   <= 1'b0;
                comment_reg  <= 1'b0;
                await_reg    <= 1'b0;
                finished_reg <= 1'b0;
                column_reg   <= '0;
                row_reg      <= '0;
                count_reg    <= '0;
                width_reg    <= '0;
                height_reg   <= '0;
            end
            else
            begin
                header_reg   <= header_next;
                comment_reg  <= comment_next;
                await_reg    <= await_next;
                finished_reg <= finished_next;
                column_reg   <= column_next;
                row_reg      <= row_next;
                count_reg    <= count_next;
                width_reg    <= width_next;
                height_reg   <= height_next;
            end
        end
    end

endmodule

/* rtl/rpd_queue.sv */
module rpd_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rpd_pkg::entry_t  entry_in,
    input  logic             pop,
    output rpd_pkg::entry_t  entry_out,
    output rpd_pkg::qstat_t  stat
);

    localparam int QPTR_W = rpd_pkg::QPTR_W;
    localparam int QDEPTH = rpd_pkg::QDEPTH;

    rpd_pkg::entry_t   mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign entry_out  = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign stat.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= entry_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + (QPTR_W+1)'(1);
                2'b01:   count_reg <= count_reg - (QPTR_W+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* rtl/rpd_emit.sv */
module rpd_emit
(
    input  logic              clk,
    input  logic              rst_n,
    input  rpd_pkg::qstat_t   stat,
    input  rpd_pkg::entry_t   entry,
    output logic              pop,
    input  logic              out_ready,
    output logic              out_valid,
    output rpd_pkg::result_t  out_res
);

    logic             valid_reg;
    logic             pend_reg;
    logic             load;
    rpd_pkg::result_t res_reg;
    rpd_pkg::result_t done_res;
    logic [8:0]       ext_w_reg;
    logic [8:0]       ext_h_reg;

    assign load      = !valid_reg || out_ready;
    assign pop       = load && !pend_reg && !stat.empty;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        done_res               = '0;
        done_res.kind          = rpd_pkg::KIND_DONE;
        done_res.extent_width  = ext_w_reg;
        done_res.extent_height = ext_h_reg;
        done_res.error_code    = rpd_pkg::ERR_RUN_BIG;
        done_res.last          = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (load)
        begin
            if (pend_reg)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end
            else if (!stat.empty)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= entry.then_done;
            end
            else
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_reg)
            begin
                res_reg <= done_res;
            end
            else if (!stat.empty)
            begin
                res_reg   <= entry.first;
                ext_w_reg <= entry.first.extent_width;
                ext_h_reg <= entry.first.extent_height;
            end
        end
    end

endmodule

/* rtl/rpd_checker.sv */
module rpd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // last marks exactly the done and error results
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser != rpd_pkg::KIND_RUN)))
        else $error("last flag does not match result kind");

    // a run record never reaches past the right edge and is never empty
    a_run_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == rpd_pkg::KIND_RUN)) |->
        ((m_tdata[24:16] != 9'd0) &&
         ({2'b00, m_tdata[7:0]} + {1'b0, m_tdata[24:16]} <= 10'(rpd_pkg::MAX_WIDTH))))
        else $error("run record outside the pattern width");

    // done results carry only the extents
    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == rpd_pkg::KIND_DONE)) |->
        ((m_tdata[29:0] == 30'd0) && (m_tdata[50:48] == 3'd0)))
        else $error("done result with record fields set");

    // error results carry a known code
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == rpd_pkg::KIND_ERROR)) |->
        (m_tdata[50:48] <= rpd_pkg::ERR_TOO_WIDE))
        else $error("error result with unknown code");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled output beat changed");

endmodule

bind rle_pattern_decoder rpd_checker u_rpd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int ITEM_TARGET = 1600;
    localparam int LONG_HOLD   = 300;
    localparam int SINK_BURST  = 150;
    localparam int HOLD_EVERY  = 500;
    localparam int PAUSE_TEXT  = 20;

    // error field reads zero on run records and done beats
    localparam rpd_pkg::err_t ERR_NONE   = rpd_pkg::err_t'(3'd0);
    localparam logic [4:0]    CELL_ALIVE = 5'd0;
    localparam logic [4:0]    CELL_DEAD  = 5'd1;

    typedef struct {
        logic [7:0]       ch;
        logic             eot;
        bit               typed;
        rpd_pkg::result_t want;
    } script_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;   // col_start, row_index, run_length, cell_state,
                            // extent_width, extent_height, error_code
    logic [1:0]  m_tuser;   // kind
    logic        m_tlast;

    // parser state mirror
    logic        in_header;
    logic        in_comment;
    logic        want_digit;
    logic        text_closed;
    logic [8:0]  cur_col;
    logic [8:0]  cur_row;
    logic [16:0] pend_count;
    logic [8:0]  span_w;
    logic [8:0]  span_h;

    rpd_pkg::result_t step_results[$];
    rpd_pkg::result_t results_due[$];
    script_row_t      script[$];
    logic [7:0]       text_buf[$];

    int fails      = 0;
    int sent_bytes = 0;
    bit tx_idle    = 1'b1;
    bit rx_idle    = 1'b1;

    rle_pattern_decoder uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic rpd_pkg::result_t mk_result(rpd_pkg::kind_t k, int cs, int ri,
                                                   int rl, int st, int w, int h,
                                                   rpd_pkg::err_t e, logic l);
        rpd_pkg::result_t r;
        r.kind          = k;
        r.col_start     = cs[7:0];
        r.row_index     = ri[7:0];
        r.run_length    = rl[8:0];
        r.cell_state    = st[4:0];
        r.extent_width  = w[8:0];
        r.extent_height = h[8:0];
        r.error_code    = e;
        r.last          = l;
        return r;
    endfunction

    function automatic void put_result(rpd_pkg::result_t r);
        step_results.insert(step_results.size(), r);
    endfunction

    function automatic void put_text(logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endfunction

    function automatic void clear_parser();
        in_header   = 1'b0;
        in_comment  = 1'b0;
        want_digit  = 1'b0;
        text_closed = 1'b0;
        cur_col     = '0;
        cur_row     = '0;
        pend_count  = '0;
        span_w      = '0;
        span_h      = '0;
    endfunction

    function automatic void raise_fault(rpd_pkg::err_t e);
        text_closed = 1'b1;
        put_result(mk_result(rpd_pkg::KIND_ERROR, 0, 0, 0, 0, span_w, span_h, e, 1'b1));
    endfunction

    function automatic void place_run(int st);
        int n;
        int reach;
        n     = pend_count;
        reach = cur_col + pend_count;
        if (cur_row >= rpd_pkg::MAX_HEIGHT)
        begin
            raise_fault(rpd_pkg::ERR_TOO_TALL);
            return;
        end
        if (reach > rpd_pkg::MAX_WIDTH)
        begin
            raise_fault(rpd_pkg::ERR_TOO_WIDE);
            return;
        end
        if (reach > span_w)
            span_w = 9'(reach);
        if (cur_row + 1 > span_h)
            span_h = 9'(cur_row + 1);
        put_result(mk_result(rpd_pkg::KIND_RUN, cur_col, cur_row, n, st,
                             span_w, span_h, ERR_NONE, 1'b0));
        cur_col    = 9'(reach);
        pend_count = '0;
    endfunction

    function automatic void decode_char(logic [7:0] c, logic eot);
        int r;
        if (want_digit)
        begin
            want_digit = 1'b0;
            if (c >= "0" && c <= "9")
                place_run(c - "0");
            else
                raise_fault(rpd_pkg::ERR_P_INCOMPLETE);
            return;
        end
        if (in_comment)
        begin
            if (c == 8'h0A)
                in_comment = 1'b0;
            return;
        end
        if (c == "#")
        begin
            in_comment = 1'b1;
            return;
        end
        if (!in_header && c == "x")
            in_header = 1'b1;
        if (in_header)
        begin
            if (c == 8'h0A)
                in_header = 1'b0;
            return;
        end
        if (c == " " || (c >= 8'd9 && c <= 8'd13))
            return;
        if (c >= "0" && c <= "9")
        begin
            r = pend_count * 10 + (c - "0");
            if (r > rpd_pkg::RUN_MAX)
                raise_fault(rpd_pkg::ERR_RUN_BIG);
            else
                pend_count = 17'(r);
            return;
        end
        if (pend_count == 0)
            pend_count = 17'd1;
        if (c == "!")
        begin
            text_closed = 1'b1;
            put_result(mk_result(rpd_pkg::KIND_DONE, 0, 0, 0, 0, span_w, span_h,
                                 ERR_NONE, 1'b1));
        end
        else if (c == "$")
        begin
            r          = cur_row + pend_count;
            cur_col    = '0;
            pend_count = '0;
            if (r > rpd_pkg::MAX_HEIGHT)
                raise_fault(rpd_pkg::ERR_TOO_TALL);
            else
                cur_row = 9'(r);
        end
        else if (c == "p" || c == "P")
        begin
            if (eot)
                raise_fault(rpd_pkg::ERR_P_INCOMPLETE);
            else
                want_digit = 1'b1;
        end
        else if (c == "b" || c == "B" || c == ".")
            place_run(CELL_DEAD);
        else if (c == "o" || c == "O" || c == "*" || c == "A")
            place_run(CELL_ALIVE);
        else if (c >= "C" && c <= "Z")
            place_run(c - "A");
        else
            raise_fault(rpd_pkg::ERR_UNKNOWN);
    endfunction

    function automatic void predict_byte(logic [7:0] c, logic eot);
        step_results.delete();
        if (!text_closed)
            decode_char(c, eot);
        if (eot)
        begin
            if (!text_closed)
                put_result(mk_result(rpd_pkg::KIND_DONE, 0, 0, 0, 0, span_w, span_h,
                                     ERR_NONE, 1'b1));
            clear_parser();
        end
    endfunction

    function automatic void add_row(logic [7:0] ch, logic eot);
        script_row_t r;
        r.ch    = ch;
        r.eot   = eot;
        r.typed = 1'b0;
        r.want  = '0;
        script.insert(script.size(), r);
    endfunction

    function automatic void add_typed(logic [7:0] ch, logic eot, rpd_pkg::result_t want);
        script_row_t r;
        r.ch    = ch;
        r.eot   = eot;
        r.typed = 1'b1;
        r.want  = want;
        script.insert(script.size(), r);
    endfunction

    function automatic logic [7:0] any_but_newline();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == 8'h0A)
            b = 8'h0B;
        return b;
    endfunction

    function automatic void push_count();
        int    pick;
        int    v;
        string s;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return;
        else if (pick < 85)
            v = $urandom_range(1, 9);
        else if (pick < 95)
            v = $urandom_range(10, 99);
        else if (pick < 99)
            v = $urandom_range(100, 300);
        else
            v = $urandom_range(1000, 99999);
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++)
            put_text(s[i]);
    endfunction

    function automatic void push_filler();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            n = $urandom_range(8, 13);
            put_text(n == 8 ? 8'h20 : n[7:0]);
        end
        else if (pick < 11)
        begin
            put_text("#");
            n = $urandom_range(0, 5);
            repeat (n) put_text(any_but_newline());
            put_text(8'h0A);
        end
        else if (pick < 12)
        begin
            put_text("x");
            n = $urandom_range(0, 5);
            repeat (n) put_text(any_but_newline());
            put_text(8'h0A);
        end
    endfunction

    function automatic void push_token();
        string cells;
        int    pick;
        cells = "bB.oO*ACDEFGHIJKLMNOPQRSTUVWXYZ";
        pick  = $urandom_range(0, 99);
        push_filler();
        push_count();
        push_filler();
        if (pick < 80)
            put_text(cells[$urandom_range(0, cells.len() - 1)]);
        else if (pick < 90)
        begin
            put_text($urandom_range(0, 1) ? "p" : "P");
            put_text(8'(48 + $urandom_range(0, 9)));
        end
        else if (pick < 92)
        begin
            put_text("p");
            put_text(cells[$urandom_range(0, cells.len() - 1)]);
        end
        else if (pick < 95)
            put_text(8'($urandom_range(0, 255)));
        else
            put_text("$");
    endfunction

    function automatic void build_text();
        int lines;
        int toks;
        int n;
        text_buf.delete();
        // broken text made of raw bytes
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 12);
            repeat (n) put_text(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 2) == 0)
        begin
            put_text("#");
            n = $urandom_range(0, 8);
            repeat (n) put_text(any_but_newline());
            put_text(8'h0A);
        end
        if ($urandom_range(0, 1) == 0)
        begin
            put_text("x");
            n = $urandom_range(0, 10);
            repeat (n) put_text(any_but_newline());
            put_text(8'h0A);
        end
        lines = $urandom_range(1, 5);
        repeat (lines)
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                put_text("2");
                put_text("5");
                put_text("6");
                put_text("$");
            end
            toks = $urandom_range(1, 6);
            repeat (toks) push_token();
            push_filler();
            push_count();
            put_text("$");
        end
        if ($urandom_range(0, 9) < 7)
        begin
            put_text("!");
            n = $urandom_range(0, 2);
            repeat (n) put_text(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_byte(input logic [7:0] ch, input logic eot);
        int gap;
        gap = tx_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent_bytes++;
        predict_byte(ch, eot);
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    function automatic void check_beat();
        rpd_pkg::result_t due;
        if (results_due.size() == 0)
        begin
            $error("result beat with nothing expected: tuser %0d tdata %h", m_tuser, m_tdata);
            fails++;
            return;
        end
        due = results_due.pop_front();
        check_field("kind",          due.kind,          m_tuser);
        check_field("col_start",     due.col_start,     m_tdata[7:0]);
        check_field("row_index",     due.row_index,     m_tdata[15:8]);
        check_field("run_length",    due.run_length,    m_tdata[24:16]);
        check_field("cell_state",    due.cell_state,    m_tdata[29:25]);
        check_field("extent_width",  due.extent_width,  m_tdata[38:30]);
        check_field("extent_height", due.extent_height, m_tdata[47:39]);
        check_field("error_code",    due.error_code,    m_tdata[50:48]);
        check_field("tdata padding", 0,                 m_tdata[55:51]);
        check_field("last",          due.last,          m_tlast);
    endfunction

    initial
    begin : result_sink
        int gap;
        int beats;
        beats = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (beats % 40 == 0)
                rx_idle = ($urandom_range(0, 3) != 0);
            gap = rx_idle ? $urandom_range(0, 8) : 0;
            // long hold so the queue fills and the input stalls
            if (beats % HOLD_EVERY == SINK_BURST)
                gap = LONG_HOLD;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            check_beat();
            beats++;
        end
    end

    initial
    begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        int text_no;
        int drain;
        clear_parser();

        // comments, header inside body with pending count, comment inside header
        add_row("#", 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(8'h0A, 1'b0);
        add_row("2", 1'b0);
        add_row("x", 1'b0);
        add_row("#", 1'b0);
        add_row(8'h0A, 1'b0);
        add_row(8'h0A, 1'b0);
        add_row(8'h09, 1'b0);
        add_typed("o", 1'b0,
                  mk_result(rpd_pkg::KIND_RUN, 0, 0, 2, CELL_ALIVE, 2, 1, ERR_NONE, 1'b0));
        add_row("$", 1'b0);
        add_row("p", 1'b0);
        add_typed("9", 1'b0,
                  mk_result(rpd_pkg::KIND_RUN, 0, 1, 1, 9, 2, 2, ERR_NONE, 1'b0));
        add_typed("!", 1'b1,
                  mk_result(rpd_pkg::KIND_DONE, 0, 0, 0, 0, 2, 2, ERR_NONE, 1'b1));
        // full-width run, then one past the edge
        add_row("2", 1'b0);
        add_row("5", 1'b0);
        add_row("6", 1'b0);
        add_row("O", 1'b0);
        add_typed(".", 1'b1, mk_result(rpd_pkg::KIND_ERROR, 0, 0, 0, 0, 256, 1,
                                       rpd_pkg::ERR_TOO_WIDE, 1'b1));
        // run count overflow
        add_row("7", 1'b0);
        add_row("0", 1'b0);
        add_row("0", 1'b0);
        add_row("0", 1'b0);
        add_typed("0", 1'b1, mk_result(rpd_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0,
                                       rpd_pkg::ERR_RUN_BIG, 1'b1));
        // row overflow
        add_row("2", 1'b0);
        add_row("5", 1'b0);
        add_row("7", 1'b0);
        add_typed("$", 1'b1, mk_result(rpd_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0,
                                       rpd_pkg::ERR_TOO_TALL, 1'b1));
        // p with a non-digit, p as final byte, unknown byte, pending count dropped
        add_row("p", 1'b0);
        add_typed("$", 1'b1, mk_result(rpd_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0,
                                       rpd_pkg::ERR_P_INCOMPLETE, 1'b1));
        add_typed("P", 1'b1, mk_result(rpd_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0,
                                       rpd_pkg::ERR_P_INCOMPLETE, 1'b1));
        add_typed(8'hFF, 1'b1, mk_result(rpd_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0,
                                         rpd_pkg::ERR_UNKNOWN, 1'b1));
        add_typed("5", 1'b1,
                  mk_result(rpd_pkg::KIND_DONE, 0, 0, 0, 0, 0, 0, ERR_NONE, 1'b1));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            send_byte(script[i].ch, script[i].eot);
            if (script[i].typed)
                results_due.insert(results_due.size(), script[i].want);
            else
                results_due = {results_due, step_results};
        end

        sent_bytes = 0;
        text_no    = 0;
        while (sent_bytes < ITEM_TARGET)
        begin
            build_text();
            tx_idle = ($urandom_range(0, 3) != 0);
            if (text_no == PAUSE_TEXT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (results_due.size() != 0) @(posedge clk);
            end
            foreach (text_buf[i])
            begin
                send_byte(text_buf[i], i == text_buf.size() - 1);
                results_due = {results_due, step_results};
            end
            text_no++;
        end
        s_tvalid <= 1'b0;

        drain = 0;
        while (results_due.size() != 0 && drain < 4000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (16) @(posedge clk);
        if (results_due.size() != 0)
        begin
            $error("%0d expected results never arrived", results_due.size());
            fails++;
        end
        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
